[sv/yin_pkg.sv]
// Shared types, constants and the lag-to-note conversion for the YIN pitch tracker.
`default_nettype none
package yin_pkg;

    localparam int POS_W       = 24;
    localparam int MAX_RESULTS = 10;
    localparam int RES_CNT_W   = 4;
    localparam int LOG_FRAC    = 24;
    localparam longint CODE_DEN = 72 * (longint'(1) <<< LOG_FRAC);

    localparam logic [1:0] REG_THRESHOLD = 2'd0;
    localparam logic [1:0] REG_SHORTEST  = 2'd1;
    localparam logic [1:0] REG_HOP       = 2'd2;

    localparam logic [15:0] THRESHOLD_RST = 16'd9830;
    localparam logic [8:0]  SHORTEST_RST  = 9'd16;
    localparam logic [10:0] HOP_RST       = 11'd160;

    typedef struct packed {
        logic done;
        logic voiced;
    } t_lag_stat;

    function automatic logic signed [POS_W-1:0] pos_diff(input logic [POS_W-1:0] a,
                                                        input logic [POS_W-1:0] b);
        pos_diff = $signed(a - b);
    endfunction

    function automatic longint log2_q24(input longint unsigned v);
        int n;
        longint unsigned m;
        longint r;
        n = 0;
        for (int k = 1; k < 30; k++) begin
            if ((v >> k) != 0) n = k;
        end
        m = v << (30 - n);
        r = longint'(n) <<< LOG_FRAC;
        for (int k = LOG_FRAC - 1; k >= 0; k--) begin
            m = (m * m) >> 30;
            if (m >= 64'h8000_0000) begin
                m = m >> 1;
                r = r + (longint'(1) <<< k);
            end
        end
        log2_q24 = r;
    endfunction

    function automatic logic [15:0] lag_code(input int lag);
        longint x;
        longint c;
        x = 45 * (longint'(1) <<< LOG_FRAC)
          + 12 * (log2_q24(400) - log2_q24(11) - log2_q24(longint'(lag)));
        if (lag < 1 || x <= 0) begin
            lag_code = 16'd0;
        end else begin
            c = (x * 32768 + CODE_DEN / 2) / CODE_DEN;
            lag_code = (c > 32768) ? 16'h8000 : c[15:0];
        end
    endfunction

endpackage
`default_nettype wire

[sv/yin_pitch_tracker_top.sv]
// Top level of the YIN pitch tracker: stream ports, register port, hop control and results.
// Each sample item is written into the sample ring and checked against the next hop start.
// The item that completes a hop's span runs the analysis on one multiply-accumulate unit
// fed by two copies of the ring, one sample pair per cycle, for each lag in turn; the
// analysis ends early when a lag is accepted. The default hop is 160 items. Results
// leave one per cycle while m_axis_tready is high, through an output register, and a
// final item can produce up to ten of them. No clearing pass is needed after reset.
`default_nettype none
module yin_pitch_tracker_top import yin_pkg::*; #(
    parameter int WINDOW_LENGTH = 1024,
    parameter int MAX_LAG       = 400,
    parameter int SAMPLE_BITS   = 16
) (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        s_axis_tvalid,
    output logic             s_axis_tready,
    input  wire logic [15:0] s_axis_tdata,   // [15:0] sample
    input  wire logic        s_axis_tlast,
    output logic             m_axis_tvalid,
    input  wire logic        m_axis_tready,
    output logic      [15:0] m_axis_tdata,   // [15:0] pitch_code
    output logic      [1:0]  m_axis_tuser,   // [0] voiced, [1] repeated
    output logic             m_axis_tlast,
    input  wire logic        psel,
    input  wire logic        penable,
    input  wire logic        pwrite,
    input  wire logic [3:0]  paddr,
    input  wire logic [31:0] pwdata,
    output logic      [31:0] prdata,
    output logic             pready
);
    localparam int RING_AW = $clog2(WINDOW_LENGTH + MAX_LAG + 1);
    localparam int LAG_W   = $clog2(MAX_LAG + 1);

    localparam logic [2:0] T_IDLE  = 3'd0;
    localparam logic [2:0] T_CHECK = 3'd1;
    localparam logic [2:0] T_WAIT  = 3'd2;
    localparam logic [2:0] T_CODE  = 3'd3;
    localparam logic [2:0] T_EMIT  = 3'd4;
    localparam logic [2:0] T_TRAIL = 3'd5;

    logic [2:0]             r_state;
    logic [15:0]            r_threshold;
    logic [8:0]             r_shortest;
    logic [10:0]            r_hop_len;
    logic [POS_W-1:0]       r_seen, r_nhs, r_pos;
    logic [15:0]            r_prev, r_code;
    logic                   r_final, r_voiced;
    logic [LAG_W-1:0]       r_lag;
    logic [RES_CNT_W-1:0]   r_n;
    logic                   r_out_valid;
    logic [15:0]            r_out_code;
    logic [1:0]             r_out_user;
    logic                   r_out_last;
    logic                   w_accept, w_cfg_wr, w_slot, w_start, w_more_now, w_more_next;
    logic                   w_emit;
    logic [10:0]            w_hop;
    logic [POS_W-1:0]       w_nhs_next;
    logic [SAMPLE_BITS-1:0] w_samp;
    t_lag_stat              w_stat;
    logic [LAG_W-1:0]       w_lag;
    logic [15:0]            w_code_tab [MAX_LAG+1];

    for (genvar g = 0; g <= MAX_LAG; g++) begin : g_code
        assign w_code_tab[g] = lag_code(g);
    end

    if (SAMPLE_BITS <= 16) begin : g_narrow
        assign w_samp = s_axis_tdata[SAMPLE_BITS-1:0];
    end else begin : g_wide
        assign w_samp = {{(SAMPLE_BITS-16){1'b0}}, s_axis_tdata};
    end

    assign s_axis_tready = (r_state == T_IDLE);
    assign w_accept      = s_axis_tvalid && s_axis_tready;
    assign pready        = 1'b1;
    assign w_cfg_wr      = psel && penable && pwrite;
    assign w_slot        = !r_out_valid || m_axis_tready;
    assign w_hop         = (r_hop_len == 11'd0) ? 11'd1 : r_hop_len;
    assign w_nhs_next    = r_nhs + POS_W'(w_hop);
    assign w_start       = (r_state == T_CHECK)
                         && (pos_diff(r_pos, r_nhs) >= $signed(POS_W'(WINDOW_LENGTH + MAX_LAG)));
    assign w_more_now    = r_final && (r_n < RES_CNT_W'(MAX_RESULTS))
                         && (pos_diff(r_seen, r_nhs) > $signed(POS_W'(1)));
    assign w_more_next   = r_final && ((r_n + RES_CNT_W'(1)) < RES_CNT_W'(MAX_RESULTS))
                         && (pos_diff(r_seen, w_nhs_next) > $signed(POS_W'(1)));
    assign w_emit        = w_slot
                         && ((r_state == T_EMIT) || ((r_state == T_TRAIL) && w_more_now));

    always_comb begin
        case (paddr[3:2])
            REG_THRESHOLD: prdata = {16'b0, r_threshold};
            REG_SHORTEST:  prdata = {23'b0, r_shortest};
            REG_HOP:       prdata = {21'b0, r_hop_len};
            default:       prdata = 32'b0;
        endcase
    end

    yin_lag_unit #(
        .WINDOW_LENGTH(WINDOW_LENGTH), .MAX_LAG(MAX_LAG), .SAMPLE_BITS(SAMPLE_BITS),
        .RING_AW(RING_AW), .LAG_W(LAG_W)
    ) u_lag (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .i_we(w_accept), .i_waddr(r_seen[RING_AW-1:0]), .i_wdata(w_samp),
        .i_start(w_start), .i_base(r_nhs[RING_AW-1:0]),
        .i_threshold(r_threshold), .i_shortest(r_shortest),
        .o_stat(w_stat), .o_lag(w_lag)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= T_IDLE;
            r_threshold <= THRESHOLD_RST;
            r_shortest  <= SHORTEST_RST;
            r_hop_len   <= HOP_RST;
            r_seen      <= '0;
            r_nhs       <= '0;
            r_prev      <= '0;
            r_n         <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (w_cfg_wr) begin
                case (paddr[3:2])
                    REG_THRESHOLD: r_threshold <= pwdata[15:0];
                    REG_SHORTEST:  r_shortest  <= pwdata[8:0];
                    REG_HOP:       r_hop_len   <= pwdata[10:0];
                    default: ;
                endcase
            end
            r_out_valid <= w_emit || (r_out_valid && !m_axis_tready);
            case (r_state)
                T_IDLE: begin
                    if (w_accept) begin
                        r_pos   <= r_seen;
                        r_seen  <= r_seen + POS_W'(1);
                        r_final <= s_axis_tlast;
                        r_state <= T_CHECK;
                    end
                end
                T_CHECK: begin
                    r_n     <= '0;
                    r_state <= w_start ? T_WAIT : T_TRAIL;
                end
                T_WAIT: begin
                    if (w_stat.done) begin
                        r_voiced <= w_stat.voiced;
                        r_lag    <= w_lag;
                        r_state  <= T_CODE;
                    end
                end
                T_CODE: begin
                    r_code  <= r_voiced ? w_code_tab[r_lag] : 16'd0;
                    r_state <= T_EMIT;
                end
                T_EMIT: begin
                    if (w_slot) begin
                        r_out_code  <= r_code;
                        r_out_user  <= {1'b0, r_voiced};
                        r_out_last  <= !w_more_next;
                        r_prev      <= r_code;
                        r_nhs       <= w_nhs_next;
                        r_n         <= RES_CNT_W'(1);
                        r_state     <= T_TRAIL;
                    end
                end
                T_TRAIL: begin
                    if (w_more_now) begin
                        if (w_slot) begin
                            r_out_code  <= r_prev;
                            r_out_user  <= 2'b10;
                            r_out_last  <= !w_more_next;
                            r_nhs       <= w_nhs_next;
                            r_n         <= r_n + RES_CNT_W'(1);
                        end
                    end else begin
                        if (r_final) begin
                            r_seen <= '0;
                            r_nhs  <= '0;
                            r_prev <= '0;
                        end
                        r_state <= T_IDLE;
                    end
                end
                default: r_state <= T_IDLE;
            endcase
        end
    end

    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = r_out_code;
    assign m_axis_tuser  = r_out_user;
    assign m_axis_tlast  = r_out_last;
endmodule
`default_nettype wire

[sv/yin_ram.sv]
// Generic single-write, single-read synchronous RAM with registered read data.
`default_nettype none
module yin_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 2048
) (
    input  wire logic                     i_clk,
    input  wire logic                     i_we,
    input  wire logic [$clog2(DEPTH)-1:0] i_waddr,
    input  wire logic [WIDTH-1:0]         i_wdata,
    input  wire logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic      [WIDTH-1:0]         o_rdata
);
    logic [WIDTH-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        o_rdata <= r_mem[i_raddr];
    end
endmodule
`default_nettype wire

[sv/yin_lag_unit.sv]
// Sample ring storage and the lag-serial difference, cumulative mean and threshold search.
`default_nettype none
module yin_lag_unit import yin_pkg::*; #(
    parameter int WINDOW_LENGTH = 1024,
    parameter int MAX_LAG       = 400,
    parameter int SAMPLE_BITS   = 16,
    parameter int RING_AW       = 11,
    parameter int LAG_W         = 9
) (
    input  wire logic                   i_clk,
    input  wire logic                   i_rst_n,
    input  wire logic                   i_we,
    input  wire logic [RING_AW-1:0]     i_waddr,
    input  wire logic [SAMPLE_BITS-1:0] i_wdata,
    input  wire logic                   i_start,
    input  wire logic [RING_AW-1:0]     i_base,
    input  wire logic [15:0]            i_threshold,
    input  wire logic [8:0]             i_shortest,
    output t_lag_stat                   o_stat,
    output logic      [LAG_W-1:0]       o_lag
);
    localparam int IW   = $clog2(WINDOW_LENGTH);
    localparam int SQW  = 2 * SAMPLE_BITS + 2;
    localparam int DW   = SQW + $clog2(WINDOW_LENGTH);
    localparam int CW   = DW + LAG_W;
    localparam int PW   = CW + 16;
    localparam int RING_DEPTH = 1 << RING_AW;

    localparam logic [2:0] U_IDLE  = 3'd0;
    localparam logic [2:0] U_MAC   = 3'd1;
    localparam logic [2:0] U_DRAIN = 3'd2;
    localparam logic [2:0] U_MUL   = 3'd3;
    localparam logic [2:0] U_CMP   = 3'd4;

    logic [2:0]             r_state, n_state;
    logic [RING_AW-1:0]     r_base;
    logic [IW-1:0]          r_i;
    logic [LAG_W-1:0]       r_lag;
    logic                   r_v1, r_v2;
    logic [SQW-1:0]         r_sq;
    logic [DW-1:0]          r_acc;
    logic [CW-1:0]          r_clo;
    logic [CW-1:0]          r_lhs;
    logic [PW-1:0]          r_rhs;
    logic                   r_done, r_voiced;
    logic                   w_issue;
    logic [RING_AW-1:0]     w_addr_a, w_addr_b;
    logic [SAMPLE_BITS-1:0] w_rd_a, w_rd_b;
    logic signed [SAMPLE_BITS:0] w_diff;
    logic                   w_pass;

    assign w_issue  = (r_state == U_MAC);
    assign w_addr_a = r_base + RING_AW'(r_i);
    assign w_addr_b = w_addr_a + RING_AW'(r_lag);
    assign w_diff   = $signed({w_rd_a[SAMPLE_BITS-1], w_rd_a})
                    - $signed({w_rd_b[SAMPLE_BITS-1], w_rd_b});
    assign w_pass   = (32'(r_lag) >= 32'(i_shortest)) && ({r_lhs, 16'b0} < r_rhs);

    yin_ram #(.WIDTH(SAMPLE_BITS), .DEPTH(RING_DEPTH)) u_ring_a (
        .i_clk(i_clk), .i_we(i_we), .i_waddr(i_waddr), .i_wdata(i_wdata),
        .i_raddr(w_addr_a), .o_rdata(w_rd_a)
    );

    yin_ram #(.WIDTH(SAMPLE_BITS), .DEPTH(RING_DEPTH)) u_ring_b (
        .i_clk(i_clk), .i_we(i_we), .i_waddr(i_waddr), .i_wdata(i_wdata),
        .i_raddr(w_addr_b), .o_rdata(w_rd_b)
    );

    always_comb begin
        n_state = r_state;
        case (r_state)
            U_IDLE:  if (i_start) n_state = U_MAC;
            U_MAC:   if (r_i == IW'(WINDOW_LENGTH - 1)) n_state = U_DRAIN;
            U_DRAIN: if (!r_v1 && !r_v2) n_state = U_MUL;
            U_MUL:   n_state = U_CMP;
            U_CMP: begin
                if (w_pass || r_lag == LAG_W'(MAX_LAG)) n_state = U_IDLE;
                else n_state = U_MAC;
            end
            default: n_state = U_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= U_IDLE;
            r_v1    <= 1'b0;
            r_v2    <= 1'b0;
            r_done  <= 1'b0;
        end else begin
            r_state <= n_state;
            r_v1    <= w_issue;
            r_v2    <= r_v1;
            r_done  <= (r_state == U_CMP) && (n_state == U_IDLE);
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_v1) r_sq <= SQW'(w_diff * w_diff);
        case (r_state)
            U_IDLE: begin
                r_base <= i_base;
                r_i    <= '0;
                r_lag  <= LAG_W'(1);
                r_acc  <= '0;
                r_clo  <= '0;
            end
            U_MAC: begin
                r_i <= r_i + IW'(1);
                if (r_v2) r_acc <= r_acc + DW'(r_sq);
            end
            U_DRAIN: begin
                if (r_v2) r_acc <= r_acc + DW'(r_sq);
                if (!r_v1 && !r_v2) r_clo <= r_clo + CW'(r_acc);
            end
            U_MUL: begin
                r_lhs <= CW'(r_acc * r_lag);
                r_rhs <= PW'(r_clo * i_threshold);
            end
            U_CMP: begin
                r_voiced <= w_pass;
                r_i      <= '0;
                r_acc    <= '0;
                if (!w_pass && r_lag != LAG_W'(MAX_LAG)) r_lag <= r_lag + LAG_W'(1);
            end
            default: ;
        endcase
    end

    assign o_stat.done   = r_done;
    assign o_stat.voiced = r_voiced;
    assign o_lag         = r_lag;
endmodule
`default_nettype wire

[sv/yin_pitch_tracker_chk.sv]
// Port-level checker for the YIN pitch tracker and its bind to the top level.
`default_nettype none
module yin_pitch_tracker_chk (
    input wire logic        i_clk,
    input wire logic        i_rst_n,
    input wire logic        m_axis_tvalid,
    input wire logic        m_axis_tready,
    input wire logic [15:0] m_axis_tdata,
    input wire logic [1:0]  m_axis_tuser,
    input wire logic        m_axis_tlast
);
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata)
        && $stable(m_axis_tuser) && $stable(m_axis_tlast))
        else $error("Stalled result item changed.");

    a_rep_unvoiced: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && m_axis_tuser[1] |-> !m_axis_tuser[0])
        else $error("Repeated result item marked voiced.");

    a_unvoiced_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && !m_axis_tuser[0] && !m_axis_tuser[1] |-> m_axis_tdata == 16'd0)
        else $error("Unvoiced analysed item carries a nonzero code.");

    a_code_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid |-> m_axis_tdata <= 16'h8000)
        else $error("Pitch code out of range.");
endmodule

bind yin_pitch_tracker_top yin_pitch_tracker_chk u_chk (
    .i_clk(i_clk), .i_rst_n(i_rst_n), .m_axis_tvalid(m_axis_tvalid),
    .m_axis_tready(m_axis_tready), .m_axis_tdata(m_axis_tdata),
    .m_axis_tuser(m_axis_tuser), .m_axis_tlast(m_axis_tlast)
);
`default_nettype wire
